FILE: src/bbsf_pkg.sv
`timescale 1ns / 1ps

package bbsf_pkg;

   localparam int BYTE_W  = 8;
   localparam int MODE_W  = 2;
   localparam int OFFS_W  = 12;
   localparam int CNT_W   = 13;
   localparam int TOTAL_W = 64;

   localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE = 2'd0,
      MODE_PEEK  = 2'd1,
      MODE_POP   = 2'd2,
      MODE_END   = 2'd3
   } mode_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_PEEK = 1'b1
   } state_type;

endpackage

FILE: src/bbsf_store.sv
`timescale 1ns / 1ps

module bbsf_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [bbsf_pkg::BYTE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [bbsf_pkg::BYTE_W-1:0] rd_data
);

   logic [bbsf_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [bbsf_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/bounded_byte_stream_fifo_unit.sv
`timescale 1ns / 1ps

// channel  direction  handshake             payload
// req      in         req_valid/req_stall   mode, data_byte, peek_offset, pop_count
// rsp      out        rsp_valid/rsp_stall   ok, out_byte, status snapshot
// csr      in         csr_valid/csr_ready   capacity_limit
//
// write, pop and end transactions complete in the idle state; a peek also passes
// through the peek state, which waits for the registered read of the byte store.
// the result sits in an output register; a new transaction is taken as the
// previous result leaves it.
// synchronous reset clears pointers, counts and flags and sets the limit to 4096.
// rsp_stall holds the result and stalls req while the result register is full.

module bounded_byte_stream_fifo_unit #(
   parameter int DEPTH = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [bbsf_pkg::MODE_W-1:0]  req_mode,
   input  logic [bbsf_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic [bbsf_pkg::OFFS_W-1:0]  req_peek_offset,
   input  logic [bbsf_pkg::CNT_W-1:0]   req_pop_count,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_ok,
   output logic [bbsf_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic [bbsf_pkg::CNT_W-1:0]   rsp_fill_level,
   output logic [bbsf_pkg::CNT_W-1:0]   rsp_room_left,
   output logic [bbsf_pkg::TOTAL_W-1:0] rsp_total_written,
   output logic [bbsf_pkg::TOTAL_W-1:0] rsp_total_read,
   output logic                         rsp_ended,
   output logic                         rsp_at_eof,
   output logic                         rsp_error_flag,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bbsf_pkg::CNT_W-1:0]   csr_capacity_limit
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = ((CW > bbsf_pkg::CNT_W) ? CW : bbsf_pkg::CNT_W) + 1;
   localparam int SW = AW + 1;
   localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

   logic [AW-1:0]                head_ff, head_in;
   logic [CW-1:0]                fill_ff, fill_in;
   logic [bbsf_pkg::TOTAL_W-1:0] wtot_ff, wtot_in;
   logic [bbsf_pkg::TOTAL_W-1:0] rtot_ff, rtot_in;
   logic                         closed_ff, closed_in;
   logic                         err_ff, err_in;
   logic [bbsf_pkg::CNT_W-1:0]   cap_ff;
   bbsf_pkg::state_type          state_ff, state_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         ok_ff, ok_in;
   logic [bbsf_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic [bbsf_pkg::CNT_W-1:0]   lvl_ff, lvl_in;
   logic [bbsf_pkg::CNT_W-1:0]   room_ff, room_in;
   logic                         eof_ff, eof_in;
   logic                         load_status;

   logic                         accept;
   logic [XW-1:0]                cap_x, fill_x, off_x, cnt_x;
   logic                         wr_en, rd_en;
   logic [AW-1:0]                wr_addr, rd_addr;
   logic [bbsf_pkg::BYTE_W-1:0]  rd_data;

   function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
      wrap = (s >= DEPTH_S) ? AW'(s - DEPTH_S) : AW'(s);
   endfunction

   function automatic logic [XW-1:0] room_of(input logic [XW-1:0] cap,
                                             input logic [XW-1:0] fill);
      room_of = (cap > fill) ? cap - fill : '0;
   endfunction

   bbsf_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != bbsf_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign cap_x  = (XW'(cap_ff) > DEPTH_X) ? DEPTH_X : XW'(cap_ff);
   assign fill_x = XW'(fill_ff);
   assign off_x  = XW'(req_peek_offset);
   assign cnt_x  = XW'(req_pop_count);

   assign wr_addr = wrap(SW'(head_ff) + SW'(fill_x));
   assign rd_addr = wrap(SW'(head_ff) + SW'(off_x));

   always_comb begin
      head_in      = head_ff;
      fill_in      = fill_ff;
      wtot_in      = wtot_ff;
      rtot_in      = rtot_ff;
      closed_in    = closed_ff;
      err_in       = err_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      ok_in        = ok_ff;
      byte_in      = byte_ff;
      load_status  = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         bbsf_pkg::ST_IDLE: begin
            if (accept) begin
               load_status = 1'b1;
               ok_in       = 1'b0;
               byte_in     = '0;
               case (req_mode)
                  bbsf_pkg::MODE_WRITE: begin
                     rsp_valid_in = 1'b1;
                     if (!closed_ff && (room_of(cap_x, fill_x) != '0)) begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + CW'(1);
                        wtot_in = wtot_ff + 64'd1;
                        ok_in   = 1'b1;
                     end
                  end
                  bbsf_pkg::MODE_PEEK: begin
                     state_in = bbsf_pkg::ST_PEEK;
                     if (off_x < fill_x) begin
                        rd_en = 1'b1;
                        ok_in = 1'b1;
                     end
                  end
                  bbsf_pkg::MODE_POP: begin
                     rsp_valid_in = 1'b1;
                     if (cnt_x > fill_x) begin
                        err_in = 1'b1;
                     end else begin
                        head_in = wrap(SW'(head_ff) + SW'(cnt_x));
                        fill_in = CW'(fill_x - cnt_x);
                        rtot_in = rtot_ff + bbsf_pkg::TOTAL_W'(req_pop_count);
                        ok_in   = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     closed_in    = 1'b1;
                     ok_in        = 1'b1;
                  end
               endcase
            end
         end
         bbsf_pkg::ST_PEEK: begin
            rsp_valid_in = 1'b1;
            byte_in      = ok_ff ? rd_data : '0;
            state_in     = bbsf_pkg::ST_IDLE;
         end
         default: begin
            state_in = bbsf_pkg::ST_IDLE;
         end
      endcase

      lvl_in  = bbsf_pkg::CNT_W'(fill_in);
      room_in = bbsf_pkg::CNT_W'(room_of(cap_x, XW'(fill_in)));
      eof_in  = closed_in && (fill_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         wtot_ff      <= '0;
         rtot_ff      <= '0;
         closed_ff    <= 1'b0;
         err_ff       <= 1'b0;
         cap_ff       <= bbsf_pkg::CAP_RESET;
         state_ff     <= bbsf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         wtot_ff      <= wtot_in;
         rtot_ff      <= rtot_in;
         closed_ff    <= closed_in;
         err_ff       <= err_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_capacity_limit;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      ok_ff   <= ok_in;
      byte_ff <= byte_in;
      if (load_status) begin
         lvl_ff  <= lvl_in;
         room_ff <= room_in;
         eof_ff  <= eof_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = ok_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_fill_level    = lvl_ff;
   assign rsp_room_left     = room_ff;
   assign rsp_total_written = wtot_ff;
   assign rsp_total_read    = rtot_ff;
   assign rsp_ended         = closed_ff;
   assign rsp_at_eof        = eof_ff;
   assign rsp_error_flag    = err_ff;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int FIFO_DEPTH  = 4096;
   localparam int SHADOW_AW   = $clog2(FIFO_DEPTH);
   localparam int EXP_AW      = 4;
   localparam int EXP_DEPTH   = 1 << EXP_AW;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic                         ok;
      logic [bbsf_pkg::BYTE_W-1:0]  out_byte;
      logic [bbsf_pkg::CNT_W-1:0]   fill_level;
      logic [bbsf_pkg::CNT_W-1:0]   room_left;
      logic [bbsf_pkg::TOTAL_W-1:0] total_written;
      logic [bbsf_pkg::TOTAL_W-1:0] total_read;
      logic                         ended;
      logic                         at_eof;
      logic                         error_flag;
   } fifo_status_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [bbsf_pkg::MODE_W-1:0]  req_mode = bbsf_pkg::MODE_WRITE;
   logic [bbsf_pkg::BYTE_W-1:0]  req_data_byte = '0;
   logic [bbsf_pkg::OFFS_W-1:0]  req_peek_offset = '0;
   logic [bbsf_pkg::CNT_W-1:0]   req_pop_count = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_ok;
   logic [bbsf_pkg::BYTE_W-1:0]  rsp_out_byte;
   logic [bbsf_pkg::CNT_W-1:0]   rsp_fill_level;
   logic [bbsf_pkg::CNT_W-1:0]   rsp_room_left;
   logic [bbsf_pkg::TOTAL_W-1:0] rsp_total_written;
   logic [bbsf_pkg::TOTAL_W-1:0] rsp_total_read;
   logic                         rsp_ended;
   logic                         rsp_at_eof;
   logic                         rsp_error_flag;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [bbsf_pkg::CNT_W-1:0]   csr_capacity_limit = bbsf_pkg::CAP_RESET;

   // shadow copy of the buffer state
   logic [bbsf_pkg::BYTE_W-1:0]  shadow_bytes [FIFO_DEPTH];
   int                           shadow_head;
   int                           shadow_fill;
   int                           shadow_cap;
   logic [bbsf_pkg::TOTAL_W-1:0] shadow_written;
   logic [bbsf_pkg::TOTAL_W-1:0] shadow_read;
   logic                         shadow_closed;
   logic                         shadow_error;

   fifo_status_type              exp_mem [EXP_DEPTH];
   int                           exp_pushed = 0;
   int                           exp_popped = 0;
   int                           src_idle_pct = 0;
   int                           sink_stall_pct = 0;
   int                           fail_count = 0;
   int                           cycle_count = 0;

   bounded_byte_stream_fifo_unit #(
      .DEPTH(FIFO_DEPTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_data_byte      (req_data_byte),
      .req_peek_offset    (req_peek_offset),
      .req_pop_count      (req_pop_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ok             (rsp_ok),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_fill_level     (rsp_fill_level),
      .rsp_room_left      (rsp_room_left),
      .rsp_total_written  (rsp_total_written),
      .rsp_total_read     (rsp_total_read),
      .rsp_ended          (rsp_ended),
      .rsp_at_eof         (rsp_at_eof),
      .rsp_error_flag     (rsp_error_flag),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_capacity_limit (csr_capacity_limit)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < sink_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** bounded_byte_stream_fifo_unit: FAILED **");
         $finish;
      end
   end

   function automatic logic [bbsf_pkg::BYTE_W-1:0] rand_byte();
      return bbsf_pkg::BYTE_W'($urandom_range(255));
   endfunction

   function automatic logic [bbsf_pkg::OFFS_W-1:0] rand_offs();
      return bbsf_pkg::OFFS_W'($urandom_range(4095));
   endfunction

   function automatic logic [bbsf_pkg::CNT_W-1:0] rand_cnt();
      return bbsf_pkg::CNT_W'($urandom_range(8191));
   endfunction

   function automatic int room_now();
      int eff;
      eff = (shadow_cap > FIFO_DEPTH) ? FIFO_DEPTH : shadow_cap;
      return (eff > shadow_fill) ? eff - shadow_fill : 0;
   endfunction

   function automatic fifo_status_type predict_status(
         input bbsf_pkg::mode_type mode,
         input logic [bbsf_pkg::BYTE_W-1:0] data,
         input logic [bbsf_pkg::OFFS_W-1:0] offs,
         input logic [bbsf_pkg::CNT_W-1:0] cnt);
      fifo_status_type r;
      r = '0;
      case (mode)
         bbsf_pkg::MODE_WRITE: begin
            if (!shadow_closed && room_now() > 0) begin
               shadow_bytes[SHADOW_AW'((shadow_head + shadow_fill) % FIFO_DEPTH)] = data;
               shadow_fill++;
               shadow_written++;
               r.ok = 1'b1;
            end
         end
         bbsf_pkg::MODE_PEEK: begin
            if (int'(offs) < shadow_fill) begin
               r.out_byte =
                  shadow_bytes[SHADOW_AW'((shadow_head + int'(offs)) % FIFO_DEPTH)];
               r.ok = 1'b1;
            end
         end
         bbsf_pkg::MODE_POP: begin
            if (int'(cnt) > shadow_fill) begin
               shadow_error = 1'b1;
            end else begin
               shadow_head = (shadow_head + int'(cnt)) % FIFO_DEPTH;
               shadow_fill -= int'(cnt);
               shadow_read = shadow_read + bbsf_pkg::TOTAL_W'(cnt);
               r.ok = 1'b1;
            end
         end
         default: begin
            shadow_closed = 1'b1;
            r.ok = 1'b1;
         end
      endcase
      r.fill_level    = bbsf_pkg::CNT_W'(shadow_fill);
      r.room_left     = bbsf_pkg::CNT_W'(room_now());
      r.total_written = shadow_written;
      r.total_read    = shadow_read;
      r.ended         = shadow_closed;
      r.at_eof        = shadow_closed && (shadow_fill == 0);
      r.error_flag    = shadow_error;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_count++;
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic compare_field(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   always @(posedge clock) begin : result_check
      fifo_status_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (exp_pushed == exp_popped) begin
            report_mismatch("result with no transaction pending", 64'd0, 64'd0);
         end else begin
            want = exp_mem[EXP_AW'(exp_popped)];
            exp_popped++;
            compare_field("ok", 64'(rsp_ok), 64'(want.ok));
            compare_field("out_byte", 64'(rsp_out_byte), 64'(want.out_byte));
            compare_field("fill_level", 64'(rsp_fill_level), 64'(want.fill_level));
            compare_field("room_left", 64'(rsp_room_left), 64'(want.room_left));
            compare_field("total_written", rsp_total_written, want.total_written);
            compare_field("total_read", rsp_total_read, want.total_read);
            compare_field("ended", 64'(rsp_ended), 64'(want.ended));
            compare_field("at_eof", 64'(rsp_at_eof), 64'(want.at_eof));
            compare_field("error_flag", 64'(rsp_error_flag), 64'(want.error_flag));
         end
      end
   end

   // called and returns at a falling edge
   task automatic send_command(input bbsf_pkg::mode_type mode,
                               input logic [bbsf_pkg::BYTE_W-1:0] data,
                               input logic [bbsf_pkg::OFFS_W-1:0] offs,
                               input logic [bbsf_pkg::CNT_W-1:0] cnt);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_data_byte   <= data;
      req_peek_offset <= offs;
      req_pop_count   <= cnt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      exp_mem[EXP_AW'(exp_pushed)] = predict_status(mode, data, offs, cnt);
      exp_pushed++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (exp_pushed != exp_popped) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [bbsf_pkg::CNT_W-1:0] value);
      wait_drained();
      csr_valid          <= 1'b1;
      csr_capacity_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_cap = int'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_traffic(input int n_items, input bit allow_close);
      int sent;
      int pick;
      int len;
      int i;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            send_command(bbsf_pkg::MODE_WRITE, rand_byte(), rand_offs(), rand_cnt());
            sent++;
         end else if (pick < 80) begin
            // read transaction: peeks from the head, then one pop
            len = (shadow_fill > 8) ? 8 : shadow_fill;
            len = $urandom_range(len);
            for (i = 0; i < len; i++) begin
               send_command(bbsf_pkg::MODE_PEEK, rand_byte(), bbsf_pkg::OFFS_W'(i),
                            rand_cnt());
            end
            send_command(bbsf_pkg::MODE_POP, rand_byte(), rand_offs(),
                         bbsf_pkg::CNT_W'(len));
            sent += len + 1;
         end else begin
            case ($urandom_range(4))
               0: send_command(bbsf_pkg::MODE_PEEK, rand_byte(), rand_offs(), rand_cnt());
               1: send_command(bbsf_pkg::MODE_POP, rand_byte(), rand_offs(), rand_cnt());
               2: send_command(bbsf_pkg::MODE_POP, rand_byte(), rand_offs(),
                               bbsf_pkg::CNT_W'($urandom_range(shadow_fill + 2)));
               3: send_command(bbsf_pkg::MODE_PEEK, rand_byte(),
                               bbsf_pkg::OFFS_W'($urandom_range(
                                  (shadow_fill > 4095) ? 4095 : shadow_fill)),
                               rand_cnt());
               default: begin
                  if (allow_close) begin
                     send_command(bbsf_pkg::MODE_END, rand_byte(), rand_offs(),
                                  rand_cnt());
                  end else begin
                     send_command(bbsf_pkg::MODE_PEEK, rand_byte(), 12'd0, 13'd0);
                  end
               end
            endcase
            sent++;
         end
      end
   endtask

   task automatic test_directed_ops();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      send_command(bbsf_pkg::MODE_WRITE, 8'h00, 12'd0, 13'd0);
      send_command(bbsf_pkg::MODE_WRITE, 8'hFF, 12'hFFF, 13'h1FFF);
      send_command(bbsf_pkg::MODE_WRITE, 8'hA5, 12'd0, 13'd0);
      send_command(bbsf_pkg::MODE_PEEK, 8'h00, 12'd0, 13'd0);
      send_command(bbsf_pkg::MODE_PEEK, 8'h00, 12'd2, 13'd0);
      // offsets at and far past the fill level
      send_command(bbsf_pkg::MODE_PEEK, 8'h00, 12'd3, 13'd0);
      send_command(bbsf_pkg::MODE_PEEK, 8'hFF, 12'hFFF, 13'h1FFF);
      send_command(bbsf_pkg::MODE_POP, 8'h00, 12'd0, 13'd0);
      send_command(bbsf_pkg::MODE_POP, 8'h00, 12'd0, 13'd1);
      // over-long pop raises the sticky error
      send_command(bbsf_pkg::MODE_POP, 8'h00, 12'd0, 13'h1FFF);
      send_command(bbsf_pkg::MODE_PEEK, 8'h00, 12'd0, 13'd0);
   endtask

   task automatic test_capacity_limits();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      write_capacity(13'd0);
      send_command(bbsf_pkg::MODE_WRITE, 8'h5A, 12'd0, 13'd0);
      // above the store depth the limit saturates
      write_capacity(13'h1FFF);
      send_command(bbsf_pkg::MODE_WRITE, 8'h3C, 12'd0, 13'd0);
      // limit dropped below the fill level
      write_capacity(13'd2);
      send_command(bbsf_pkg::MODE_WRITE, 8'h77, 12'd0, 13'd0);
      send_command(bbsf_pkg::MODE_POP, 8'h00, 12'd0, 13'd2);
      send_command(bbsf_pkg::MODE_WRITE, 8'h11, 12'd0, 13'd0);
      send_command(bbsf_pkg::MODE_WRITE, 8'h22, 12'd0, 13'd0);
      send_command(bbsf_pkg::MODE_POP, 8'h00, 12'd0, 13'd2);
   endtask

   task automatic test_traffic_no_idle();
      write_capacity(bbsf_pkg::CAP_RESET);
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      random_traffic(65, 1'b0);
      wait_drained();
      random_traffic(65, 1'b0);
   endtask

   task automatic test_traffic_sender_idle();
      write_capacity(13'd1);
      src_idle_pct   = 86;
      sink_stall_pct = 0;
      random_traffic(130, 1'b0);
   endtask

   task automatic test_traffic_receiver_stall();
      write_capacity(13'h1FFF);
      src_idle_pct   = 0;
      sink_stall_pct = 86;
      random_traffic(130, 1'b0);
   endtask

   task automatic test_traffic_both_idle();
      write_capacity(bbsf_pkg::CNT_W'($urandom_range(64, 2)));
      src_idle_pct   = 29;
      sink_stall_pct = 29;
      random_traffic(130, 1'b0);
   endtask

   task automatic test_end_of_input();
      src_idle_pct   = 29;
      sink_stall_pct = 29;
      send_command(bbsf_pkg::MODE_WRITE, 8'hC3, 12'd0, 13'd0);
      send_command(bbsf_pkg::MODE_END, 8'h00, 12'd0, 13'd0);
      send_command(bbsf_pkg::MODE_WRITE, 8'h5A, 12'd0, 13'd0);
      send_command(bbsf_pkg::MODE_END, 8'h00, 12'd0, 13'd0);
      send_command(bbsf_pkg::MODE_PEEK, 8'h00, 12'd0, 13'd0);
      // draining a closed stream reaches eof
      send_command(bbsf_pkg::MODE_POP, 8'h00, 12'd0, bbsf_pkg::CNT_W'(shadow_fill));
      send_command(bbsf_pkg::MODE_POP, 8'h00, 12'd0, 13'd0);
      random_traffic(30, 1'b1);
   endtask

   initial begin
      shadow_head    = 0;
      shadow_fill    = 0;
      shadow_cap     = int'(bbsf_pkg::CAP_RESET);
      shadow_written = '0;
      shadow_read    = '0;
      shadow_closed  = 1'b0;
      shadow_error   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_ops();
      test_capacity_limits();
      test_traffic_no_idle();
      test_traffic_sender_idle();
      test_traffic_receiver_stall();
      test_traffic_both_idle();
      test_end_of_input();

      wait_drained();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("** bounded_byte_stream_fifo_unit: PASSED **");
      end else begin
         $display("** bounded_byte_stream_fifo_unit: FAILED **");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/bbsf_pkg.sv
src/bbsf_store.sv
src/bounded_byte_stream_fifo_unit.sv
sim/testbench.sv
